### rtl/kvi_pkg.sv
// Shared types and constants for the keyframe vector interpolator.
// No dependencies; every other file in rtl/ imports this package.
package kvi_pkg;

   // Key table geometry.
   localparam int MAX_KEYS  = 64;
   localparam int KEY_IDX_W = $clog2(MAX_KEYS);
   localparam int COUNT_W   = 7;

   // Fixed point format of the interpolation factor.
   localparam int FRAC_BITS = 16;
   localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

   // Widths of times and vector components.
   localparam int TIME_W = 32;
   localparam int VAL_W  = 32;

   // Command codes of an input transfer.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Result status codes.
   localparam logic [2:0] STAT_INTERP     = 3'd0;
   localparam logic [2:0] STAT_SINGLE     = 3'd1;
   localparam logic [2:0] STAT_CLAMP_LOW  = 3'd2;
   localparam logic [2:0] STAT_CLAMP_HIGH = 3'd3;
   localparam logic [2:0] STAT_ZERO_SPAN  = 3'd4;

   // Component select for the shared interpolation unit.
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   // One row of the vector table.
   typedef struct packed {
      logic signed [VAL_W-1:0] z;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] x;
   } vec_type;

   // Table write request.
   typedef struct packed {
      logic                 en;
      logic [KEY_IDX_W-1:0] addr;
      logic [TIME_W-1:0]    key_time;
      vec_type              vec;
   } key_wr_type;

endpackage

### rtl/keyframe_vector_interpolator.sv
// Keyframe vector interpolator. A load transfer writes one key in its accept cycle and
// keeps busy low. A query holds busy until its result, and longer for a later segment s: the
// key scan reads the keys one at a time over the single time-table read port, and an
// interpolated result also waits for the 16-step divider.
// One result strobe per query; the receiver cannot stall. Reset sets the key count to 1 and
// leaves the key table undefined until written. Depends on kvi_pkg and the kvi_* modules.
module keyframe_vector_interpolator import kvi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_command,
   input  logic [5:0]              req_key_slot,
   input  logic [TIME_W-1:0]       req_key_time,
   input  logic signed [VAL_W-1:0] req_key_x,
   input  logic signed [VAL_W-1:0] req_key_y,
   input  logic signed [VAL_W-1:0] req_key_z,
   input  logic [TIME_W-1:0]       req_frame_time,
   input  logic                    csr_wr_en,
   input  logic [COUNT_W-1:0]      csr_wr_data,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_out_x,
   output logic signed [VAL_W-1:0] rsp_out_y,
   output logic signed [VAL_W-1:0] rsp_out_z,
   output logic [5:0]              rsp_segment,
   output logic [2:0]              rsp_status
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_TRD    = 10'b0000000010,
      S_TCHK   = 10'b0000000100,
      S_ARD    = 10'b0000001000,
      S_KEYOUT = 10'b0000010000,
      S_BRD    = 10'b0000100000,
      S_BCAP   = 10'b0001000000,
      S_DIVW   = 10'b0010000000,
      S_LERP   = 10'b0100000000,
      S_DRAIN  = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   keys_ff, keys_in;
   logic [TIME_W-1:0]    t_ff, t_in;
   logic [KEY_IDX_W-1:0] last_ff, last_in;
   logic [KEY_IDX_W-1:0] idx_ff, idx_in;
   logic [TIME_W-1:0]    prev_ff, prev_in;
   logic [KEY_IDX_W-1:0] key_ff, key_in;
   logic [2:0]           status_ff, status_in;
   vec_type              a_ff, a_in;
   vec_type              b_ff, b_in;
   logic [1:0]           comp_ff, comp_in;
   logic [1:0]           col_ff, col_in;
   logic [VAL_W-1:0]     rx_ff, rx_in;
   logic [VAL_W-1:0]     ry_ff, ry_in;
   logic [VAL_W-1:0]     rz_ff, rz_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic [KEY_IDX_W-1:0] n_last;
   key_wr_type           key_wr;
   logic [KEY_IDX_W-1:0] time_addr;
   logic [TIME_W-1:0]    time_rd;
   logic [KEY_IDX_W-1:0] vec_addr;
   vec_type              vec_rd;
   logic                 div_start;
   logic [TIME_W-1:0]    div_num;
   logic [TIME_W-1:0]    div_den;
   logic                 div_done;
   logic [FRAC_BITS-1:0] div_quo;
   logic                 lerp_in_valid;
   logic signed [VAL_W-1:0] lerp_a;
   logic signed [VAL_W-1:0] lerp_b;
   logic                 lerp_out_valid;
   logic [VAL_W-1:0]     lerp_out;

   assign accept = start && !busy;

   // Last usable key index: a count of zero acts as one, a count past the table as full.
   always_comb begin
      if (keys_ff == '0) begin
         n_last = '0;
      end else if (keys_ff > COUNT_W'(MAX_KEYS)) begin
         n_last = KEY_IDX_W'(MAX_KEYS - 1);
      end else begin
         n_last = KEY_IDX_W'(keys_ff - 1'b1);
      end
   end

   // A load transfer writes the key table directly.
   always_comb begin
      key_wr.en       = accept && (req_command == CMD_LOAD);
      key_wr.addr     = req_key_slot[KEY_IDX_W-1:0];
      key_wr.key_time = req_key_time;
      key_wr.vec.x    = req_key_x;
      key_wr.vec.y    = req_key_y;
      key_wr.vec.z    = req_key_z;
   end

   kvi_key_mem u_key_mem (
      .clock     (clock),
      .wr        (key_wr),
      .time_addr (time_addr),
      .time_rd   (time_rd),
      .vec_addr  (vec_addr),
      .vec_rd    (vec_rd)
   );

   kvi_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   kvi_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lerp_in_valid),
      .in_a      (lerp_a),
      .in_b      (lerp_b),
      .in_frac   (div_quo),
      .out_valid (lerp_out_valid),
      .out_value (lerp_out)
   );

   // Component feed for the lerp unit.
   always_comb begin
      case (comp_ff)
         COMP_X: begin
            lerp_a = a_ff.x;
            lerp_b = b_ff.x;
         end
         COMP_Y: begin
            lerp_a = a_ff.y;
            lerp_b = b_ff.y;
         end
         default: begin
            lerp_a = a_ff.z;
            lerp_b = b_ff.z;
         end
      endcase
   end

   // Sequencer: scan the time table, then read vectors, divide and interpolate.
   always_comb begin
      state_in      = state_ff;
      keys_in       = keys_ff;
      t_in          = t_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      comp_in       = comp_ff;
      col_in        = col_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rz_in         = rz_ff;
      rsp_valid_in  = 1'b0;
      time_addr     = idx_ff;
      vec_addr      = key_ff;
      div_start     = 1'b0;
      div_num       = t_ff - prev_ff;
      div_den       = time_rd - prev_ff;
      lerp_in_valid = 1'b0;

      if (csr_wr_en) begin
         keys_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == CMD_QUERY)) begin
               t_in    = req_frame_time;
               last_in = n_last;
               idx_in  = '0;
               if (n_last == '0) begin
                  key_in    = '0;
                  status_in = STAT_SINGLE;
                  state_in  = S_ARD;
               end else begin
                  state_in = S_TRD;
               end
            end
         end
         S_TRD: begin
            state_in = S_TCHK;
         end
         S_TCHK: begin
            if (idx_ff == '0) begin
               if (t_ff < time_rd) begin
                  key_in    = '0;
                  status_in = STAT_CLAMP_LOW;
                  state_in  = S_ARD;
               end else begin
                  prev_in  = time_rd;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TRD;
               end
            end else if (t_ff < time_rd) begin
               // First key whose time exceeds the frame time closes the segment.
               key_in   = idx_ff - 1'b1;
               state_in = S_ARD;
               if ((time_rd <= prev_ff) || (t_ff < prev_ff)) begin
                  status_in = STAT_ZERO_SPAN;
               end else begin
                  status_in = STAT_INTERP;
                  div_start = 1'b1;
               end
            end else if (idx_ff == last_ff) begin
               key_in    = last_ff;
               status_in = STAT_CLAMP_HIGH;
               state_in  = S_ARD;
            end else begin
               prev_in  = time_rd;
               idx_in   = idx_ff + 1'b1;
               state_in = S_TRD;
            end
         end
         S_ARD: begin
            if (status_ff == STAT_INTERP) begin
               state_in = S_BRD;
            end else begin
               state_in = S_KEYOUT;
            end
         end
         S_KEYOUT: begin
            rx_in        = vec_rd.x;
            ry_in        = vec_rd.y;
            rz_in        = vec_rd.z;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_BRD: begin
            vec_addr = key_ff + 1'b1;
            a_in     = vec_rd;
            state_in = S_BCAP;
         end
         S_BCAP: begin
            b_in     = vec_rd;
            comp_in  = COMP_X;
            col_in   = COMP_X;
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               state_in = S_LERP;
            end
         end
         S_LERP: begin
            lerp_in_valid = 1'b1;
            comp_in       = comp_ff + 1'b1;
            if (comp_ff == COMP_Z) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (lerp_out_valid && (col_ff == COMP_Z)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Collect lerp results as they leave the pipeline.
      if (lerp_out_valid) begin
         col_in = col_ff + 1'b1;
         case (col_ff)
            COMP_X:  rx_in = lerp_out;
            COMP_Y:  ry_in = lerp_out;
            default: rz_in = lerp_out;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         keys_ff      <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         comp_ff      <= COMP_X;
         col_ff       <= COMP_X;
      end else begin
         state_ff     <= state_in;
         keys_ff      <= keys_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         comp_ff      <= comp_in;
         col_ff       <= col_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      last_ff   <= last_in;
      prev_ff   <= prev_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rz_ff     <= rz_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = rx_ff;
   assign rsp_out_y   = ry_ff;
   assign rsp_out_z   = rz_ff;
   assign rsp_segment = 6'(key_ff);
   assign rsp_status  = status_ff;

endmodule

### rtl/kvi_key_mem.sv
// Key table: time memory and vector memory, one write port and one
// registered read port each. Depends on kvi_pkg.
module kvi_key_mem import kvi_pkg::*; (
   input  logic                 clock,
   input  key_wr_type           wr,
   input  logic [KEY_IDX_W-1:0] time_addr,
   output logic [TIME_W-1:0]    time_rd,
   input  logic [KEY_IDX_W-1:0] vec_addr,
   output vec_type              vec_rd
);

   logic [TIME_W-1:0] time_mem [MAX_KEYS];
   vec_type           vec_mem  [MAX_KEYS];
   logic [TIME_W-1:0] time_rd_ff;
   vec_type           vec_rd_ff;

   // Time memory.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         time_mem[wr.addr] <= wr.key_time;
      end
      time_rd_ff <= time_mem[time_addr];
   end

   // Vector memory.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         vec_mem[wr.addr] <= wr.vec;
      end
      vec_rd_ff <= vec_mem[vec_addr];
   end

   assign time_rd = time_rd_ff;
   assign vec_rd  = vec_rd_ff;

endmodule

### rtl/kvi_divider.sv
// Restoring divider for the interpolation factor, one quotient bit a cycle.
// Computes floor((num << FRAC_BITS) / den) for num < den. Depends on kvi_pkg.
module kvi_divider import kvi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_W-1:0]    num,
   input  logic [TIME_W-1:0]    den,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quo
);

   logic                 run_ff,  run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic [TIME_W-1:0]    rem_ff,  rem_in;
   logic [TIME_W-1:0]    den_ff,  den_in;
   logic [FRAC_BITS-1:0] quo_ff,  quo_in;
   logic [TIME_W:0]      rem_shift;
   logic [TIME_W:0]      rem_diff;

   // One shift-and-subtract step per cycle.
   always_comb begin
      run_in    = run_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      rem_shift = {rem_ff, 1'b0};
      rem_diff  = rem_shift - {1'b0, den_ff};
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
      end else if (run_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[TIME_W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[TIME_W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(FRAC_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### rtl/kvi_lerp.sv
// Shared lerp unit: start + floor((end - start) * factor / 2^FRAC_BITS),
// two register stages, one component per transfer. Depends on kvi_pkg.
module kvi_lerp import kvi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [VAL_W-1:0] in_a,
   input  logic signed [VAL_W-1:0] in_b,
   input  logic [FRAC_BITS-1:0]    in_frac,
   output logic                    out_valid,
   output logic [VAL_W-1:0]        out_value
);

   localparam int DIFF_W = VAL_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

   logic                     v1_ff, v2_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [VAL_W-1:0]  a1_ff, a2_ff;
   logic [FRAC_BITS-1:0]     frac1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [FRAC_BITS:0] frac_s;

   assign frac_s = $signed({1'b0, frac1_ff});

   // Valid pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // Stage one takes the difference, stage two the product.
   always_ff @(posedge clock) begin
      diff_ff  <= DIFF_W'(in_b) - DIFF_W'(in_a);
      a1_ff    <= in_a;
      frac1_ff <= in_frac;
      prod_ff  <= diff_ff * frac_s;
      a2_ff    <= a1_ff;
   end

   // The arithmetic shift floors toward minus infinity; only 32 bits survive.
   assign out_value = a2_ff + prod_ff[FRAC_BITS +: VAL_W];
   assign out_valid = v2_ff;

endmodule

### sim/kvi_checker.sv
// Checker for the keyframe vector interpolator: watches the command, register and result ports,
// keeps its own copy of the key table and key count, predicts every query and compares fields.
// Depends on kvi_pkg for widths, command codes, status codes and the vector row type.
module kvi_checker
   import kvi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_command,
   input  logic [5:0]              req_key_slot,
   input  logic [TIME_W-1:0]       req_key_time,
   input  logic signed [VAL_W-1:0] req_key_x,
   input  logic signed [VAL_W-1:0] req_key_y,
   input  logic signed [VAL_W-1:0] req_key_z,
   input  logic [TIME_W-1:0]       req_frame_time,
   input  logic                    csr_wr_en,
   input  logic [COUNT_W-1:0]      csr_wr_data,
   input  logic                    rsp_valid,
   input  logic signed [VAL_W-1:0] rsp_out_x,
   input  logic signed [VAL_W-1:0] rsp_out_y,
   input  logic signed [VAL_W-1:0] rsp_out_z,
   input  logic [5:0]              rsp_segment,
   input  logic [2:0]              rsp_status,
   output int                      failures,
   output int                      outstanding,
   output int                      loads_seen,
   output int                      results_seen,
   output int                      interp_seen,
   output int                      single_seen,
   output int                      clamp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted result of a query.
   typedef struct {
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
      logic [5:0]              segment;
      logic [2:0]              status;
   } frame_result_type;

   // Shadow of the key table and the key count register.
   logic [TIME_W-1:0]  key_time_tbl [MAX_KEYS];
   vec_type            key_vec_tbl [MAX_KEYS];
   logic [COUNT_W-1:0] key_count;
   frame_result_type   pending_frames [$];

   initial begin
      failures     = 0;
      outstanding  = 0;
      loads_seen   = 0;
      results_seen = 0;
      interp_seen  = 0;
      single_seen  = 0;
      clamp_seen   = 0;
      key_count    = 1;
      for (int k = 0; k < MAX_KEYS; k++) begin
         key_time_tbl[k] = '0;
         key_vec_tbl[k]  = '0;
      end
   end

   // Moves one component from its start value toward its end value by a Q0.16 factor,
   // with the scaled difference rounded toward minus infinity.
   function automatic logic signed [VAL_W-1:0] blend_component(
      input logic signed [VAL_W-1:0] from_val,
      input logic signed [VAL_W-1:0] to_val,
      input longint                  factor
   );
      longint diff;
      longint scaled;
      logic signed [63:0] sum;
      diff   = longint'(to_val) - longint'(from_val);
      scaled = diff * factor;
      sum    = longint'(from_val) + (scaled >>> FRAC_BITS);
      return sum[VAL_W-1:0];
   endfunction

   // Works out the result of a query at the given frame time from the shadow table.
   function automatic frame_result_type interpolate_frame(input logic [TIME_W-1:0] frame);
      frame_result_type res;
      int            used;
      int            seg;
      int            pick;
      int            i;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] t1;
      logic [TIME_W-1:0] offset;
      logic [63:0]   numer;
      logic [63:0]   factor;
      used = key_count;
      if (used < 1) used = 1;
      if (used > MAX_KEYS) used = MAX_KEYS;
      pick = 0;
      seg  = used;
      t0   = '0;
      t1   = '0;
      if (used == 1) begin
         res.status = STAT_SINGLE;
      end else if (frame < key_time_tbl[0]) begin
         res.status = STAT_CLAMP_LOW;
      end else begin
         // First segment whose end time lies beyond the frame time.
         for (i = 0; i + 1 < used; i++) begin
            if (seg == used && frame < key_time_tbl[i+1]) seg = i;
         end
         if (seg == used) begin
            pick       = used - 1;
            res.status = STAT_CLAMP_HIGH;
         end else begin
            pick = seg;
            t0   = key_time_tbl[seg];
            t1   = key_time_tbl[seg+1];
            if (t1 <= t0 || frame < t0) res.status = STAT_ZERO_SPAN;
            else res.status = STAT_INTERP;
         end
      end
      res.segment = pick[5:0];
      if (res.status == STAT_INTERP) begin
         offset = frame - t0;
         numer  = {32'd0, offset} << FRAC_BITS;
         factor = numer / {32'd0, t1 - t0};
         res.x  = blend_component(key_vec_tbl[pick].x, key_vec_tbl[pick+1].x, longint'(factor));
         res.y  = blend_component(key_vec_tbl[pick].y, key_vec_tbl[pick+1].y, longint'(factor));
         res.z  = blend_component(key_vec_tbl[pick].z, key_vec_tbl[pick+1].z, longint'(factor));
      end else begin
         res.x = key_vec_tbl[pick].x;
         res.y = key_vec_tbl[pick].y;
         res.z = key_vec_tbl[pick].z;
      end
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: MISMATCH %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Track register writes and input transfers, then check each result transfer.
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         key_count = 1;
         pending_frames.delete();
      end else begin
         if (csr_wr_en) key_count = csr_wr_data;
         if (start && !busy) begin
            if (req_command == CMD_LOAD) begin
               key_time_tbl[req_key_slot]  = req_key_time;
               key_vec_tbl[req_key_slot].x = req_key_x;
               key_vec_tbl[req_key_slot].y = req_key_y;
               key_vec_tbl[req_key_slot].z = req_key_z;
               loads_seen++;
            end else begin
               pending_frames.insert(pending_frames.size(), interpolate_frame(req_frame_time));
            end
         end
         if (rsp_valid) begin
            if (pending_frames.size() == 0) begin
               failures++;
               $display("%0t: MISMATCH result with no query pending, expected none",
                        $time);
               $display("   actual x=%h y=%h z=%h seg=%0d status=%0d",
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_segment, rsp_status);
            end else begin
               want = pending_frames.pop_front();
               results_seen++;
               case (want.status)
                  STAT_INTERP:                     interp_seen++;
                  STAT_SINGLE:                     single_seen++;
                  STAT_CLAMP_LOW, STAT_CLAMP_HIGH: clamp_seen++;
                  default: ;
               endcase
               compare_field("out_x", want.x, rsp_out_x);
               compare_field("out_y", want.y, rsp_out_y);
               compare_field("out_z", want.z, rsp_out_z);
               compare_field("segment", want.segment, rsp_segment);
               compare_field("status", want.status, rsp_status);
            end
         end
      end
      outstanding <= pending_frames.size();
   end

endmodule

### sim/testbench.sv
// Top of the keyframe vector interpolator simulation: clock, reset, key loads, queries and
// key count writes, a watchdog and the verdict. Depends on kvi_pkg, the RTL and kvi_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import kvi_pkg::*;

   // Longest quiet stretch in a correct run is a drain pause plus a long gap and a query.
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 120;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_command = CMD_LOAD;
   logic [5:0]              req_key_slot = '0;
   logic [TIME_W-1:0]       req_key_time = '0;
   logic signed [VAL_W-1:0] req_key_x = '0;
   logic signed [VAL_W-1:0] req_key_y = '0;
   logic signed [VAL_W-1:0] req_key_z = '0;
   logic [TIME_W-1:0]       req_frame_time = '0;
   logic                    csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]      csr_wr_data = '0;
   logic                    rsp_valid;
   logic signed [VAL_W-1:0] rsp_out_x;
   logic signed [VAL_W-1:0] rsp_out_y;
   logic signed [VAL_W-1:0] rsp_out_z;
   logic [5:0]              rsp_segment;
   logic [2:0]              rsp_status;

   int failures;
   int outstanding;
   int loads_seen;
   int results_seen;
   int interp_seen;
   int single_seen;
   int clamp_seen;
   int idle_cycles = 0;
   int no_gap_run = 0;
   int settings_used = 0;

   // Key times as last loaded, used only to aim queries at interesting times.
   logic [TIME_W-1:0] shadow_time [MAX_KEYS];

   always #1 clock = ~clock;

   keyframe_vector_interpolator DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_key_slot   (req_key_slot),
      .req_key_time   (req_key_time),
      .req_key_x      (req_key_x),
      .req_key_y      (req_key_y),
      .req_key_z      (req_key_z),
      .req_frame_time (req_frame_time),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_segment    (rsp_segment),
      .rsp_status     (rsp_status)
   );

   kvi_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_key_slot   (req_key_slot),
      .req_key_time   (req_key_time),
      .req_key_x      (req_key_x),
      .req_key_y      (req_key_y),
      .req_key_z      (req_key_z),
      .req_frame_time (req_frame_time),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_segment    (rsp_segment),
      .rsp_status     (rsp_status),
      .failures       (failures),
      .outstanding    (outstanding),
      .loads_seen     (loads_seen),
      .results_seen   (results_seen),
      .interp_seen    (interp_seen),
      .single_seen    (single_seen),
      .clamp_seen     (clamp_seen)
   );

   // Watchdog: any transfer or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Gap before the next transfer: mostly none or short, a few long, and bursts with none.
   function automatic int pick_gap();
      int r;
      if (no_gap_run > 0) begin
         no_gap_run--;
         return 0;
      end
      r = $urandom_range(99, 0);
      if (r < 3) begin
         no_gap_run = $urandom_range(40, 10);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(80, 20);
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(9, 0))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(200, 0) - 100;
         default: return $urandom();
      endcase
   endfunction

   // Drives one command and holds it until the block takes it.
   task automatic transfer(input logic cmd, input logic [5:0] slot, input logic [31:0] ktime,
                           input logic [31:0] kx, input logic [31:0] ky, input logic [31:0] kz,
                           input logic [31:0] frame);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command    <= cmd;
      req_key_slot   <= slot;
      req_key_time   <= ktime;
      req_key_x      <= kx;
      req_key_y      <= ky;
      req_key_z      <= kz;
      req_frame_time <= frame;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_key(input logic [5:0] slot, input logic [31:0] ktime,
                           input logic [31:0] kx, input logic [31:0] ky, input logic [31:0] kz);
      transfer(CMD_LOAD, slot, ktime, kx, ky, kz, $urandom());
      shadow_time[slot] = ktime;
   endtask

   // Unused key fields carry random values so the block is seen to ignore them.
   task automatic query_frame(input logic [31:0] frame);
      transfer(CMD_QUERY, 6'($urandom_range(63, 0)), $urandom(), random_value(),
               random_value(), random_value(), frame);
   endtask

   // Waits until the block is quiet and every result is in, then writes the key count.
   task automatic set_key_count(input logic [COUNT_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Loads keys 0..n-1 with rising times; wide or narrow spacing, a few repeated times.
   task automatic fill_table(input int n);
      logic [31:0] t;
      longint      room;
      int unsigned step_max;
      int          s;
      t = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(5000, 0);
      room = (longint'(32'hFFFF_FFFF) - longint'(t)) / n;
      step_max = ($urandom_range(1, 0) == 1 || room < 4000) ? int'(room) : 4000;
      if (step_max == 0) step_max = 1;
      for (s = 0; s < n; s++) begin
         load_key(s[5:0], t, random_value(), random_value(), random_value());
         if ($urandom_range(19, 0) != 0) t = t + $urandom_range(step_max, 1);
      end
   endtask

   // Frame times aimed at the key range, at key times, next to them and outside the range.
   function automatic logic [31:0] pick_frame_time(input int n);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] key_t;
      lo    = shadow_time[0];
      hi    = shadow_time[n-1];
      key_t = shadow_time[$urandom_range(n - 1, 0)];
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return (hi > lo) ? lo + $urandom_range(hi - lo, 0) : lo;
         4, 5:       return key_t;
         6:          return ($urandom_range(1, 0) == 1) ? key_t + 1 : key_t - 1;
         7:          return $urandom();
         8:          return ($urandom_range(1, 0) == 1) ? 32'hFFFF_FFFF : 32'h0;
         default:    return (lo > 0) ? $urandom_range(lo - 1, 0) : 32'h0;
      endcase
   endfunction

   // Reloads one key with a time that keeps the table in order where there is room.
   task automatic reload_in_order(input int n);
      int          s;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] t;
      s  = $urandom_range(n - 1, 0);
      lo = (s > 0) ? shadow_time[s-1] : 32'h0;
      hi = (s < n - 1) ? shadow_time[s+1] : 32'hFFFF_FFFF;
      t  = (hi >= lo) ? lo + $urandom_range(hi - lo, 0) : $urandom();
      load_key(s[5:0], t, random_value(), random_value(), random_value());
   endtask

   // One phase: a key count, a fresh ordered table, then mostly queries with some reloads.
   task automatic run_phase(input logic [COUNT_W-1:0] setting);
      int n;
      int i;
      int r;
      set_key_count(setting);
      n = (setting == 0) ? 1 : (setting > MAX_KEYS) ? MAX_KEYS : int'(setting);
      fill_table(n);
      for (i = 0; i < PHASE_ITEMS; i++) begin
         r = $urandom_range(99, 0);
         if (r < 65) query_frame(pick_frame_time(n));
         else if (r < 90) reload_in_order(n);
         else load_key(6'($urandom_range(63, 0)), $urandom(), random_value(), random_value(),
                       random_value());
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] count_plan [$];
      count_plan = '{7'd2, 7'd64, 7'd127, 7'd3, 7'd0, 7'd65, 7'd1, 7'd17, 7'd100,
                     7'($urandom_range(127, 1)), 7'($urandom_range(64, 2))};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Single key, and a count of zero that acts as one.
      set_key_count(7'd1);
      load_key(6'd0, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      query_frame(32'h0);
      query_frame(32'hFFFF_FFFF);
      set_key_count(7'd0);
      query_frame(32'd5);

      // Four keys with full-scale swings, a repeated time and a last key at the top time.
      set_key_count(7'd4);
      load_key(6'd1, 32'd2000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      load_key(6'd2, 32'd2000, 32'h0, 32'h1, 32'h7FFF_FFFF);
      load_key(6'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      query_frame(32'd999);
      query_frame(32'd1000);
      query_frame(32'd1500);
      query_frame(32'd1999);
      query_frame(32'd2000);
      query_frame(32'd3000);
      query_frame(32'hFFFF_FFFE);
      query_frame(32'hFFFF_FFFF);
      load_key(6'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
      query_frame(32'd0);
      query_frame(32'd1999);

      // Random phases over a range of key counts, the extremes among them.
      foreach (count_plan[p]) run_phase(count_plan[p]);

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d key loads and %0d query results over %0d key count settings.",
               loads_seen, results_seen, settings_used);
      $display("Results: %0d interpolated, %0d single key, %0d clamped; %0d mismatches.",
               interp_seen, single_seen, clamp_seen, failures);
      if (failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/kvi_pkg.sv
rtl/kvi_key_mem.sv
rtl/kvi_divider.sv
rtl/kvi_lerp.sv
rtl/keyframe_vector_interpolator.sv
sim/kvi_checker.sv
sim/testbench.sv
